// ----- hdl/apl_pkg.sv -----
package apl_pkg;

   // Field and register widths
   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS   = 24;
   localparam int REG_BITS    = 24;
   localparam int PROD_BITS   = 2 * REG_BITS;
   localparam int CSR_IDX_BITS = 3;

   // Saturation limits
   localparam logic [REG_BITS-1:0] LEVEL_MAX  = REG_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic [REG_BITS-1:0] TIMER_MAX  = '1;
   localparam logic [REG_BITS-1:0] PHASE_HALF = REG_BITS'(1) << (REG_BITS - 1);

   // Galois LFSR taps, x^24+x^23+x^22+x^17+1
   localparam logic [REG_BITS-1:0] LFSR_TAPS = 24'hE10000;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_BITS-1:0] CSR_GREEN_DECAY     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RED_DECAY       = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GREEN_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RED_THRESHOLD   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLINK_THRESHOLD = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLD_FRAMES     = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLINK_STEP      = 3'd6;

   // Register reset values
   localparam logic [REG_BITS-1:0] RST_GREEN_DECAY     = 24'd16775795;
   localparam logic [REG_BITS-1:0] RST_RED_DECAY       = 24'd16776820;
   localparam logic [REG_BITS-1:0] RST_GREEN_THRESHOLD = 24'd1056053;
   localparam logic [REG_BITS-1:0] RST_RED_THRESHOLD   = 24'd4204487;
   localparam logic [REG_BITS-1:0] RST_BLINK_THRESHOLD = 24'd7476354;
   localparam logic [REG_BITS-1:0] RST_HOLD_FRAMES     = 24'd48000;
   localparam logic [REG_BITS-1:0] RST_BLINK_STEP      = 24'd1748;

   // Dither seeds
   localparam logic [REG_BITS-1:0] SEED_GREEN = 24'h000001;
   localparam logic [REG_BITS-1:0] SEED_RED   = 24'h00ACE1;

   typedef struct packed {
      logic [REG_BITS-1:0] green_decay;
      logic [REG_BITS-1:0] red_decay;
      logic [REG_BITS-1:0] green_threshold;
      logic [REG_BITS-1:0] red_threshold;
      logic [REG_BITS-1:0] blink_threshold;
      logic [REG_BITS-1:0] hold_frames;
      logic [REG_BITS-1:0] blink_step;
   } cfg_type;

   typedef struct packed {
      logic                green_led;
      logic                red_led;
      logic [REG_BITS-1:0] green_level;
      logic [REG_BITS-1:0] red_level;
   } rsp_type;

   // Absolute value; the most negative sample maps to 2^(SAMPLE_BITS-1)
   function automatic logic [REG_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] s);
      logic [SAMPLE_BITS-1:0] m;
      m = s[SAMPLE_BITS-1] ? (~s + SAMPLE_BITS'(1)) : s;
      return REG_BITS'(m);
   endfunction

   function automatic logic [REG_BITS-1:0] lfsr_next(input logic [REG_BITS-1:0] s);
      logic [REG_BITS-1:0] t;
      t = s >> 1;
      if (s[0]) begin
         t = t ^ LFSR_TAPS;
      end
      return t;
   endfunction

   function automatic logic [REG_BITS-1:0] timer_inc(input logic [REG_BITS-1:0] t);
      return (t == TIMER_MAX) ? TIMER_MAX : t + REG_BITS'(1);
   endfunction

   // (peak * mult) >> FRAC_BITS, clipped at full scale
   function automatic logic [REG_BITS-1:0] decay(input logic [REG_BITS-1:0] peak,
                                                 input logic [REG_BITS-1:0] mult);
      logic [PROD_BITS-1:0] prod;
      logic [REG_BITS-1:0]  r;
      prod = PROD_BITS'(peak) * PROD_BITS'(mult);
      r    = prod[FRAC_BITS +: REG_BITS];
      return (r > LEVEL_MAX) ? LEVEL_MAX : r;
   endfunction

endpackage

// ----- hdl/audio_peak_led_meter.sv -----
// Peak LED meter with exponential decay, hold and blink.
// Input channel (req_*): one two-channel audio frame per beat, signed samples.
// Result channel (rsp_*): one beat per frame with the green and red LED drives
// and the decayed green and red peak levels.
// Both channels move a beat on a rising edge with valid high and stall low.
// Configuration (csr_*): write-only; a write lands on the edge with
// csr_write_enable high. Unknown indexes are ignored. Write only while idle.
// A frame passes through the input register and then the output register.
// Throughput: one frame per cycle while the receiver does not stall. A frame
// sits in the input register, and the decay multiplies, timer updates and PWM
// compares run in the cycle that moves it into the output register, updating
// the meter state too. When the receiver stalls, the output beat holds and one
// more frame can wait in the input register before req_stall rises.
// Reset clears both peaks, the hold and blink timers and the blink phase,
// seeds the dither LFSRs and loads the default register values. Since the
// timers start at zero, hold and blink are active for the first
// hold_frames - 1 frames after reset.
module audio_peak_led_meter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [apl_pkg::SAMPLE_BITS-1:0] req_sample_a,
   input  logic signed [apl_pkg::SAMPLE_BITS-1:0] req_sample_b,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_green_led,
   output logic                                   rsp_red_led,
   output logic        [apl_pkg::REG_BITS-1:0]    rsp_green_level,
   output logic        [apl_pkg::REG_BITS-1:0]    rsp_red_level,
   input  logic                                   csr_write_enable,
   input  logic        [apl_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic        [apl_pkg::REG_BITS-1:0]    csr_wdata
);

   apl_pkg::cfg_type cfg_ff;
   apl_pkg::rsp_type result;
   apl_pkg::rsp_type rsp_ff;

   logic                            in_valid_ff;
   logic [apl_pkg::SAMPLE_BITS-1:0] sample_a_ff;
   logic [apl_pkg::SAMPLE_BITS-1:0] sample_b_ff;
   logic                            rsp_valid_ff;
   logic                            advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.green_decay     <= apl_pkg::RST_GREEN_DECAY;
         cfg_ff.red_decay       <= apl_pkg::RST_RED_DECAY;
         cfg_ff.green_threshold <= apl_pkg::RST_GREEN_THRESHOLD;
         cfg_ff.red_threshold   <= apl_pkg::RST_RED_THRESHOLD;
         cfg_ff.blink_threshold <= apl_pkg::RST_BLINK_THRESHOLD;
         cfg_ff.hold_frames     <= apl_pkg::RST_HOLD_FRAMES;
         cfg_ff.blink_step      <= apl_pkg::RST_BLINK_STEP;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            apl_pkg::CSR_GREEN_DECAY:     cfg_ff.green_decay     <= csr_wdata;
            apl_pkg::CSR_RED_DECAY:       cfg_ff.red_decay       <= csr_wdata;
            apl_pkg::CSR_GREEN_THRESHOLD: cfg_ff.green_threshold <= csr_wdata;
            apl_pkg::CSR_RED_THRESHOLD:   cfg_ff.red_threshold   <= csr_wdata;
            apl_pkg::CSR_BLINK_THRESHOLD: cfg_ff.blink_threshold <= csr_wdata;
            apl_pkg::CSR_HOLD_FRAMES:     cfg_ff.hold_frames     <= csr_wdata;
            apl_pkg::CSR_BLINK_STEP:      cfg_ff.blink_step      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame moves to the output register when that register is free or drains
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         sample_a_ff <= req_sample_a;
         sample_b_ff <= req_sample_b;
      end
   end

   apl_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .sample_a (sample_a_ff),
      .sample_b (sample_b_ff),
      .cfg      (cfg_ff),
      .result   (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_green_led   = rsp_ff.green_led;
   assign rsp_red_led     = rsp_ff.red_led;
   assign rsp_green_level = rsp_ff.green_level;
   assign rsp_red_level   = rsp_ff.red_level;

   // Input stalls only with a frame held behind a stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked output");

   // A frame moved forward always shows on the result channel
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced frame lost");

   // An accepted beat always lands in the input register
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> in_valid_ff)
      else $error("accepted beat dropped");

endmodule

// ----- hdl/apl_core.sv -----
module apl_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic        [apl_pkg::SAMPLE_BITS-1:0] sample_a,
   input  logic        [apl_pkg::SAMPLE_BITS-1:0] sample_b,
   input  apl_pkg::cfg_type                       cfg,
   output apl_pkg::rsp_type                       result
);

   localparam int W = apl_pkg::REG_BITS;
   localparam int P = apl_pkg::PROD_BITS;

   logic [W-1:0] green_peak_ff,   green_peak_in;
   logic [W-1:0] red_peak_ff,     red_peak_in;
   logic [W-1:0] hold_timer_ff,   hold_timer_in;
   logic [W-1:0] blink_timer_ff,  blink_timer_in;
   logic [W-1:0] blink_phase_ff,  blink_phase_in;
   logic [W-1:0] dither_green_ff, dither_green_in;
   logic [W-1:0] dither_red_ff,   dither_red_in;

   logic [W-1:0] mag_a, mag_b, mag;
   logic [W-1:0] green_lift, red_lift;
   logic [W-1:0] red_excess;
   logic [P-1:0] green_draw, red_draw;
   logic         green_on, dither_red_on, hold_on, blink_on, red_on;

   // Frame magnitude and peak lift
   assign mag_a      = apl_pkg::magnitude(sample_a);
   assign mag_b      = apl_pkg::magnitude(sample_b);
   assign mag        = (mag_a > mag_b) ? mag_a : mag_b;
   assign green_lift = (mag > green_peak_ff) ? mag : green_peak_ff;
   assign red_lift   = (mag > red_peak_ff)   ? mag : red_peak_ff;

   // Decay, one multiplier per tracker
   assign green_peak_in = apl_pkg::decay(green_lift, cfg.green_decay);
   assign red_peak_in   = apl_pkg::decay(red_lift, cfg.red_decay);

   // Timers restart on trigger, then count up saturating
   assign hold_timer_in  = (red_peak_in > cfg.red_threshold) ? W'(1)
                         : apl_pkg::timer_inc(hold_timer_ff);
   assign blink_timer_in = (red_peak_in > cfg.blink_threshold) ? W'(1)
                         : apl_pkg::timer_inc(blink_timer_ff);

   // Blink phase wraps modulo 2^24; dither advances one step per frame
   assign blink_phase_in  = blink_phase_ff + cfg.blink_step;
   assign dither_green_in = apl_pkg::lfsr_next(dither_green_ff);
   assign dither_red_in   = apl_pkg::lfsr_next(dither_red_ff);

   // PWM compares: draw * scale against level << 24
   assign green_draw    = P'(dither_green_in) * P'(cfg.green_threshold);
   assign red_draw      = P'(dither_red_in) * P'(cfg.red_threshold);
   assign red_excess    = red_peak_in - cfg.green_threshold;
   assign green_on      = green_draw < {green_peak_in, {W{1'b0}}};
   assign dither_red_on = (red_peak_in > cfg.green_threshold)
                       && (red_draw < {red_excess, {W{1'b0}}});
   assign hold_on       = hold_timer_in < cfg.hold_frames;
   assign blink_on      = blink_timer_in < cfg.hold_frames;

   // Blink overrides hold, hold overrides dither
   always_comb begin
      priority if (blink_on) begin
         red_on = blink_phase_in < apl_pkg::PHASE_HALF;
      end else if (hold_on) begin
         red_on = 1'b1;
      end else begin
         red_on = dither_red_on;
      end
   end

   assign result.green_led   = green_on;
   assign result.red_led     = red_on;
   assign result.green_level = green_peak_in;
   assign result.red_level   = red_peak_in;

   // Meter state, committed once per frame
   always_ff @(posedge clock) begin
      if (reset) begin
         green_peak_ff   <= '0;
         red_peak_ff     <= '0;
         hold_timer_ff   <= '0;
         blink_timer_ff  <= '0;
         blink_phase_ff  <= '0;
         dither_green_ff <= apl_pkg::SEED_GREEN;
         dither_red_ff   <= apl_pkg::SEED_RED;
      end else if (advance) begin
         green_peak_ff   <= green_peak_in;
         red_peak_ff     <= red_peak_in;
         hold_timer_ff   <= hold_timer_in;
         blink_timer_ff  <= blink_timer_in;
         blink_phase_ff  <= blink_phase_in;
         dither_green_ff <= dither_green_in;
         dither_red_ff   <= dither_red_in;
      end
   end

   // LFSRs never lock up at zero
   a_dither_nonzero: assert property (@(posedge clock) disable iff (reset)
      dither_green_ff != '0 && dither_red_ff != '0)
      else $error("dither LFSR reached zero");

   // Peaks never exceed full scale
   a_peak_range: assert property (@(posedge clock) disable iff (reset)
      green_peak_ff <= apl_pkg::LEVEL_MAX && red_peak_ff <= apl_pkg::LEVEL_MAX)
      else $error("peak above full scale");

   // A red trigger leaves the hold timer at one
   a_hold_restart: assert property (@(posedge clock) disable iff (reset)
      advance && (red_peak_in > cfg.red_threshold) |=> hold_timer_ff == W'(1))
      else $error("hold timer not restarted");

endmodule
